// ===== src/pip_pkg.sv =====
package pip_pkg;

    // Fixed field widths of the channels and the configuration register.
    localparam int CFG_W         = 10;
    localparam int IDX_FIELD_W   = 9;
    localparam int COORD_FIELD_W = 32;

    // Smallest vertex count that forms a polygon.
    localparam int MIN_POLY_VERTICES = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_edge_status;

endpackage

// ===== src/pip_if.sv =====
interface pip_in_if import pip_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic        [IDX_FIELD_W-1:0]   vertex_index;
    logic signed [COORD_FIELD_W-1:0] coord_x;
    logic signed [COORD_FIELD_W-1:0] coord_y;

    modport source (
        output valid, operation, vertex_index, coord_x, coord_y,
        input  ready
    );
    modport sink (
        input  valid, operation, vertex_index, coord_x, coord_y,
        output ready
    );
endinterface

interface pip_out_if import pip_pkg::*; ();
    logic valid;
    logic ready;
    logic inside_res;
    logic polygon_valid;

    modport source (
        output valid, inside_res, polygon_valid,
        input  ready
    );
    modport sink (
        input  valid, inside_res, polygon_valid,
        output ready
    );
endinterface

// ===== src/point_in_polygon_test.sv =====
// Vertex write: one transaction per cycle while no query is in progress, no result.
// Query with n vertices in use (n at least three): the vertex store is read
// once per cycle over n + 1 reads; the result follows the last edge.
// Query with fewer than three vertices: no store read, result straight from ST_DONE.
// Reset clears the vertex count and the control state; the vertex store is
// not cleared and holds nothing defined until written.
module point_in_polygon_test import pip_pkg::*; #(
    parameter int MAX_VERTICES = 512,
    parameter int COORD_BITS   = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wen,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    pip_in_if.sink           i_in,
    pip_out_if.source        o_res
);

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int DATA_W = 2 * COORD_BITS;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [31:0]      cfg_wide;

    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] last_idx;
    logic             r_first;
    logic             r_rd_vld;
    logic             r_rd_first;

    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic signed [COORD_BITS-1:0] r_prev_x;
    logic signed [COORD_BITS-1:0] r_prev_y;
    logic signed [COORD_BITS-1:0] cur_x;
    logic signed [COORD_BITS-1:0] cur_y;

    logic r_parity;
    logic r_polyok;
    logic r_out_valid;
    logic r_out_inside;
    logic r_out_polyok;

    logic in_ready;
    logic rd_en;
    logic load_out;
    logic in_acc;
    logic start;
    logic short_poly;
    logic idx_ok;
    logic mem_wen;

    logic [DATA_W-1:0] rdata;
    t_edge_status      edge_st;

    assign in_acc     = i_in.valid && in_ready;
    assign start      = in_acc && (i_in.operation == OP_QUERY);
    assign short_poly = 32'(r_count) < MIN_POLY_VERTICES;
    assign last_idx   = IDX_W'(r_count - CNT_W'(1));
    assign idx_ok     = 32'(i_in.vertex_index) < MAX_VERTICES;
    assign mem_wen    = in_acc && (i_in.operation == OP_WRITE) && idx_ok;

    // A count above the store's depth is saturated when it is written.
    assign cfg_wide = 32'(i_cfg_wdata);
    assign n_count  = (cfg_wide > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                     : CNT_W'(cfg_wide);

    pip_vstore #(
        .DEPTH  (MAX_VERTICES),
        .DATA_W (DATA_W)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_wen   (mem_wen),
        .i_waddr (IDX_W'(i_in.vertex_index)),
        .i_wdata ({i_in.coord_y[COORD_BITS-1:0], i_in.coord_x[COORD_BITS-1:0]}),
        .i_ren   (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    assign cur_x = rdata[COORD_BITS-1:0];
    assign cur_y = rdata[DATA_W-1:COORD_BITS];

    // The first read of a query fetches the last vertex, which only primes the
    // predecessor register; every later read closes one edge.
    pip_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_vld && !r_rd_first),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_cx     (cur_x),
        .i_cy     (cur_y),
        .i_qx     (r_prev_x),
        .i_qy     (r_prev_y),
        .o_status (edge_st)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = short_poly ? ST_DONE : ST_READ;
                end
            end
            ST_READ: begin
                if (!r_first && (r_addr == last_idx)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !edge_st.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_READ: begin
                rd_en = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                load_out = !r_out_valid || o_res.ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (i_cfg_wen) begin
                r_count <= n_count;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_px     <= i_in.coord_x[COORD_BITS-1:0];
            r_py     <= i_in.coord_y[COORD_BITS-1:0];
            r_addr   <= last_idx;
            r_first  <= 1'b1;
            r_parity <= 1'b0;
            r_polyok <= !short_poly;
        end else begin
            if (rd_en) begin
                r_addr  <= r_first ? '0 : r_addr + IDX_W'(1);
                r_first <= 1'b0;
            end
            if (edge_st.hit) begin
                r_parity <= !r_parity;
            end
        end
        if (rd_en) begin
            r_rd_first <= r_first;
        end
        if (r_rd_vld) begin
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
        end
        if (load_out) begin
            r_out_inside <= r_parity && r_polyok;
            r_out_polyok <= r_polyok;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.inside_res    = r_out_inside;
    assign o_res.polygon_valid = r_out_polyok;

`ifndef SYNTH
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_rd_vld && !edge_st.busy))
        else $error("edge pipeline still busy while idle");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (32'(r_addr) < 32'(r_count)))
        else $error("vertex read beyond the count in use");

    a_polyok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_polyok) |-> (32'(r_count) >= MIN_POLY_VERTICES))
        else $error("valid polygon reported with too few vertices");

    a_hit_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        edge_st.hit |-> (r_state == ST_DRAIN || r_state == ST_READ))
        else $error("edge crossing outside a query walk");
`endif

endmodule

// ===== src/pip_vstore.sv =====
module pip_vstore #(
    parameter int DEPTH  = 512,
    parameter int DATA_W = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wen,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_ren,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ren) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pip_edge.sv =====
module pip_edge import pip_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    output t_edge_status                 o_status
);

    localparam int D_W = COORD_BITS + 1;
    localparam int P_W = 2 * D_W;

    // Stage one: differences and the straddle test.
    logic                  r_s1_vld;
    logic                  r_s1_straddle;
    logic                  r_s1_dy_pos;
    logic signed [D_W-1:0] r_a;
    logic signed [D_W-1:0] r_b;
    logic signed [D_W-1:0] r_c;
    logic signed [D_W-1:0] r_d;

    // Stage two: the two exact products.
    logic                  r_s2_vld;
    logic                  r_s2_straddle;
    logic                  r_s2_dy_pos;
    logic signed [P_W-1:0] r_l;
    logic signed [P_W-1:0] r_r;

    // Stage three: the crossing decision.
    logic r_s3_vld;
    logic r_s3_hit;

    logic n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_straddle <= (i_cy > i_py) != (i_qy > i_py);
        r_s1_dy_pos   <= i_qy > i_cy;
        r_a           <= D_W'(i_px) - D_W'(i_cx);
        r_b           <= D_W'(i_qy) - D_W'(i_cy);
        r_c           <= D_W'(i_qx) - D_W'(i_cx);
        r_d           <= D_W'(i_py) - D_W'(i_cy);

        r_s2_straddle <= r_s1_straddle;
        r_s2_dy_pos   <= r_s1_dy_pos;
        r_l           <= P_W'(r_a) * P_W'(r_b);
        r_r           <= P_W'(r_c) * P_W'(r_d);

        r_s3_hit      <= n_hit;
    end

    // The sense of the comparison follows the sign of the edge's Y difference,
    // which stands in for the division of the textbook test.
    always_comb begin
        n_hit = r_s2_vld && r_s2_straddle &&
                (r_s2_dy_pos ? (r_l < r_r) : (r_r < r_l));
    end

    assign o_status.busy = r_s1_vld || r_s2_vld || r_s3_vld;
    assign o_status.hit  = r_s3_vld && r_s3_hit;

endmodule

// ===== test/tb.sv =====
module tb;
    import pip_pkg::*;

    localparam int STORE_DEPTH    = 512;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [COORD_FIELD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_FIELD_W-1:0] COORD_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                            op;
        logic        [IDX_FIELD_W-1:0]   idx;
        logic signed [COORD_FIELD_W-1:0] x;
        logic signed [COORD_FIELD_W-1:0] y;
    } t_vertex_cmd;

    typedef struct packed {
        logic in_poly;
        logic poly_ok;
    } t_verdict;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wen;
    logic [CFG_W-1:0] cfg_wdata;

    pip_in_if  in_ch ();
    pip_out_if res_ch ();

    point_in_polygon_test #(
        .MAX_VERTICES (STORE_DEPTH),
        .COORD_BITS   (COORD_FIELD_W)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_res       (res_ch)
    );

    always #5 clk = ~clk;

    // Commands waiting for the driver and verdicts waiting for the monitor.
    t_vertex_cmd cmd_q[$];
    t_verdict    verdict_q[$];
    t_vertex_cmd cur_cmd;

    // Predictor state, updated as transactions are accepted.
    logic signed [COORD_FIELD_W-1:0] vtx_x [STORE_DEPTH];
    logic signed [COORD_FIELD_W-1:0] vtx_y [STORE_DEPTH];
    int unsigned                     vertex_count_reg;

    // Stimulus-side copy of what has been queued, so that no query reads an
    // entry that was never written.
    bit                              planned [STORE_DEPTH];
    logic signed [COORD_FIELD_W-1:0] plan_x [STORE_DEPTH];
    logic signed [COORD_FIELD_W-1:0] plan_y [STORE_DEPTH];

    int unsigned cycle_no;
    int unsigned idle_cycles;
    int unsigned mismatches;
    int unsigned writes_done;
    int unsigned queries_done;
    int unsigned results_seen;
    int unsigned inside_seen;
    int unsigned outside_seen;
    int unsigned degenerate_seen;
    int unsigned settings_used;

    // While steady() holds, the driver and the monitor run without gaps.
    function automatic bit steady();
        return (cycle_no % 8000) < 2000;
    endfunction

    function automatic bit take_turn();
        return steady() || ($urandom_range(99) >= 33);
    endfunction

    // Even-odd crossing test over the first n stored vertices. Products are
    // kept exact at 68 bits, so the comparison needs no division.
    function automatic logic point_inside(input logic signed [COORD_FIELD_W-1:0] px,
                                          input logic signed [COORD_FIELD_W-1:0] py,
                                          input int unsigned n);
        logic                            parity;
        int unsigned                     prv;
        logic signed [COORD_FIELD_W+1:0] dy;
        logic signed [2*COORD_FIELD_W+3:0] lhs;
        logic signed [2*COORD_FIELD_W+3:0] rhs;
        logic                            hit;
        parity = 1'b0;
        prv    = n - 1;
        for (int unsigned i = 0; i < n; i++) begin
            if ((vtx_y[i] > py) != (vtx_y[prv] > py)) begin
                dy  = vtx_y[prv] - vtx_y[i];
                lhs = (px - vtx_x[i]) * dy;
                rhs = (vtx_x[prv] - vtx_x[i]) * (py - vtx_y[i]);
                hit = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
                if (hit)
                    parity = ~parity;
            end
            prv = i;
        end
        return parity;
    endfunction

    task automatic apply_cmd(input t_vertex_cmd c);
        t_verdict    v;
        int unsigned n;
        n = (vertex_count_reg > STORE_DEPTH) ? STORE_DEPTH : vertex_count_reg;
        if (c.op == OP_WRITE) begin
            vtx_x[c.idx] = c.x;
            vtx_y[c.idx] = c.y;
            writes_done++;
        end else begin
            if (n < MIN_POLY_VERTICES) begin
                v.in_poly = 1'b0;
                v.poly_ok = 1'b0;
                degenerate_seen++;
            end else begin
                v.in_poly = point_inside(c.x, c.y, n);
                v.poly_ok = 1'b1;
                if (v.in_poly)
                    inside_seen++;
                else
                    outside_seen++;
            end
            verdict_q.push_back(v);
            queries_done++;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic want, input logic got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("tb: mismatch on %s at result %0d: expected %0b, got %0b",
                     what, results_seen, want, got);
    endtask

    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
    end

    // Driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                apply_cmd(cur_cmd);
            if (!in_ch.valid || in_ch.ready) begin
                if (cmd_q.size() != 0 && take_turn()) begin
                    cur_cmd = cmd_q.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.operation    <= cur_cmd.op;
                    in_ch.vertex_index <= cur_cmd.idx;
                    in_ch.coord_x      <= cur_cmd.x;
                    in_ch.coord_y      <= cur_cmd.y;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("tb: result %0d arrived with none expected (inside %0b, valid %0b)",
                                 results_seen, res_ch.inside_res, res_ch.polygon_valid);
                end else begin
                    t_verdict want;
                    want = verdict_q.pop_front();
                    if (res_ch.inside_res !== want.in_poly)
                        flag_mismatch("inside_res", want.in_poly, res_ch.inside_res);
                    if (res_ch.polygon_valid !== want.poly_ok)
                        flag_mismatch("polygon_valid", want.poly_ok, res_ch.polygon_valid);
                end
            end
            res_ch.ready <= take_turn();
        end
    end

    // Watchdog on cycles in which neither channel completes a transaction.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: no transaction for %0d cycles", idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic queue_write(input int unsigned idx,
                               input logic signed [COORD_FIELD_W-1:0] x,
                               input logic signed [COORD_FIELD_W-1:0] y);
        t_vertex_cmd c;
        c.op  = OP_WRITE;
        c.idx = IDX_FIELD_W'(idx);
        c.x   = x;
        c.y   = y;
        planned[idx] = 1'b1;
        plan_x[idx]  = x;
        plan_y[idx]  = y;
        cmd_q.push_back(c);
    endtask

    task automatic queue_query(input logic signed [COORD_FIELD_W-1:0] x,
                               input logic signed [COORD_FIELD_W-1:0] y);
        t_vertex_cmd c;
        c.op  = OP_QUERY;
        c.idx = IDX_FIELD_W'($urandom);
        c.x   = x;
        c.y   = y;
        cmd_q.push_back(c);
    endtask

    // Waits until every queued transaction is accepted and every verdict has
    // been checked, then lets the block finish any trailing work.
    task automatic settle();
        while (cmd_q.size() != 0 || in_ch.valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_vertex_count(input int unsigned n);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= CFG_W'(n);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        vertex_count_reg = n;
        settings_used++;
    endtask

    // Mostly coordinates within the phase's span, so that edges and query
    // points share Y values often; now and then the full range.
    function automatic logic signed [COORD_FIELD_W-1:0] pick_coord(input int unsigned span);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return COORD_MIN;
        if (r < 8)
            return COORD_MAX;
        if (r < 16)
            return $urandom;
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    initial begin
        int unsigned phase;
        int unsigned random_items;
        int unsigned n;
        int unsigned eff;
        int unsigned span;
        int unsigned len;
        int unsigned k;
        int unsigned r;

        rst_n              = 1'b0;
        cfg_wen            = 1'b0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.operation    = OP_WRITE;
        in_ch.vertex_index = '0;
        in_ch.coord_x      = '0;
        in_ch.coord_y      = '0;
        res_ch.ready       = 1'b0;
        cycle_no           = 0;
        idle_cycles        = 0;
        mismatches         = 0;
        vertex_count_reg   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // An empty polygon and a two-vertex one are both degenerate.
        set_vertex_count(0);
        queue_query(0, 0);
        settle();
        set_vertex_count(2);
        queue_write(0, COORD_MIN, COORD_MIN);
        queue_write(1, COORD_MAX, COORD_MAX);
        queue_query(0, 0);
        settle();

        // Triangle spanning the whole coordinate range.
        set_vertex_count(MIN_POLY_VERTICES);
        queue_write(2, COORD_MIN, COORD_MAX);
        queue_query(-32'sd1073741824, 32'sd1073741824);
        queue_query(32'sd1073741824, -32'sd1073741824);
        queue_query(COORD_MAX, COORD_MAX);
        queue_query(COORD_MIN, 0);
        queue_query(COORD_MAX, COORD_MIN);
        queue_query(COORD_MIN, COORD_MAX);
        settle();

        // Square with horizontal edges; points on edges and on vertex heights.
        set_vertex_count(4);
        queue_write(0, 0, 0);
        queue_write(1, 256, 0);
        queue_write(2, 256, 256);
        queue_write(3, 0, 256);
        queue_write(STORE_DEPTH - 1, COORD_MAX, COORD_MIN);
        queue_query(128, 128);
        queue_query(128, 0);
        queue_query(300, 256);
        queue_query(0, 128);
        queue_query(256, 128);
        queue_query(-1, 128);
        settle();

        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (phase == 3)
                n = STORE_DEPTH;
            else if (phase == 7)
                n = (1 << CFG_W) - 1;
            else if (phase == 11)
                n = $urandom_range(STORE_DEPTH + 1, (1 << CFG_W) - 2);
            else if (r < 8)
                n = $urandom_range(0, MIN_POLY_VERTICES - 1);
            else if (r < 20)
                n = $urandom_range(17, 48);
            else
                n = $urandom_range(MIN_POLY_VERTICES, 16);
            set_vertex_count(n);
            eff = (n > STORE_DEPTH) ? STORE_DEPTH : n;
            case ($urandom_range(3))
                0:       span = 8;
                1:       span = 200;
                2:       span = 70000;
                default: span = 1 << 30;
            endcase

            for (int unsigned i = 0; i < eff; i++) begin
                if (!planned[i] || $urandom_range(3) != 0) begin
                    queue_write(i, pick_coord(span), pick_coord(span));
                    random_items++;
                end
            end

            // Queries over hundreds of vertices are slow, so phases of more than 48
            // vertices carry only four commands, queries and writes mixed.
            len = (eff > 48) ? 4 : $urandom_range(15, 50);
            for (k = 0; k < len; k++) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    if (r < 8 && eff > 0) begin
                        n = $urandom_range(0, eff - 1);
                        queue_query(plan_x[n], plan_y[n]);
                    end else begin
                        queue_query(pick_coord(span), pick_coord(span));
                    end
                end else if (r < 90 && eff > 0) begin
                    queue_write($urandom_range(0, eff - 1), pick_coord(span), pick_coord(span));
                end else begin
                    queue_write($urandom_range(0, STORE_DEPTH - 1), pick_coord(span),
                                pick_coord(span));
                end
                random_items++;
            end
            settle();
            phase++;
        end

        settle();
        $display("tb: %0d vertex writes and %0d queries over %0d vertex-count settings",
                 writes_done, queries_done, settings_used);
        $display("tb: %0d results checked: %0d inside, %0d outside, %0d degenerate",
                 results_seen, inside_seen, outside_seen, degenerate_seen);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pip_pkg.sv
src/pip_if.sv
src/pip_vstore.sv
src/pip_edge.sv
src/point_in_polygon_test.sv
test/tb.sv
